// ===== hdl/gbr_pkg.sv =====
// Package for the RGBA Gaussian blur: widths, register indexes, weight tables.
// No dependencies.
`default_nettype none
package gbr_pkg;
  localparam int DefMaxWidth = 256;
  localparam int DefMaxHeight = 256;
  localparam int DefMaxRadius = 4;
  localparam int TableRadii = 4;
  localparam int TableTaps = 12;
  localparam int TapW = 4;
  localparam int SelW = 2;

  localparam logic [1:0] REG_RADIUS = 2'd0;
  localparam logic [1:0] REG_WIDTH  = 2'd1;
  localparam logic [1:0] REG_HEIGHT = 2'd2;

  localparam logic FUNC_WRITE = 1'b0;
  localparam logic FUNC_READ  = 1'b1;

  // Window reach per radius
  function automatic logic [TapW-1:0] reach_of(input logic [SelW-1:0] sel);
    logic [TapW-1:0] r;
    begin
      case (sel)
        2'd0: r = 4'd3;
        2'd1: r = 4'd6;
        2'd2: r = 4'd8;
        default: r = 4'd11;
      endcase
      return r;
    end
  endfunction

  // Q0.16 Gaussian weight per radius and distance
  function automatic logic [15:0] weight_of(input logic [SelW-1:0] sel,
                                            input logic [TapW-1:0] d);
    logic [15:0] w;
    begin
      w = 16'd0;
      case (sel)
        2'd0: case (d)
          4'd0: w = 16'd65535; 4'd1: w = 16'd39750; 4'd2: w = 16'd8869;
          4'd3: w = 16'd728; default: w = 16'd0;
        endcase
        2'd1: case (d)
          4'd0: w = 16'd65535; 4'd1: w = 16'd57835; 4'd2: w = 16'd39750;
          4'd3: w = 16'd21276; 4'd4: w = 16'd8869; 4'd5: w = 16'd2879;
          4'd6: w = 16'd728; default: w = 16'd0;
        endcase
        2'd2: case (d)
          4'd0: w = 16'd65535; 4'd1: w = 16'd61994; 4'd2: w = 16'd52477;
          4'd3: w = 16'd39750; 4'd4: w = 16'd26943; 4'd5: w = 16'd16342;
          4'd6: w = 16'd8869; 4'd7: w = 16'd4308; 4'd8: w = 16'd1872;
          default: w = 16'd0;
        endcase
        default: case (d)
          4'd0: w = 16'd65535; 4'd1: w = 16'd63520; 4'd2: w = 16'd57835;
          4'd3: w = 16'd49469; 4'd4: w = 16'd39750; 4'd5: w = 16'd30005;
          4'd6: w = 16'd21276; 4'd7: w = 16'd14173; 4'd8: w = 16'd8869;
          4'd9: w = 16'd5214; 4'd10: w = 16'd2879; 4'd11: w = 16'd1494;
          default: w = 16'd0;
        endcase
      endcase
      return w;
    end
  endfunction

  // Controller to datapath commands
  typedef struct packed {
    logic load;     // latch request, set up window
    logic step;     // issue one window read and advance
    logic acc;      // accumulate the beat read last cycle
    logic div_go;   // start the dividers
    logic emit;     // load output register
  } gbr_cmd_t;

  typedef struct packed {
    logic last;     // current read address is the window's last
    logic div_done;
  } gbr_stat_t;
endpackage
`default_nettype wire

// ===== hdl/gbr_if.sv =====
// Valid/ready channel interfaces for the blur block.
// Depends on nothing.
`default_nettype none
interface gbr_in_if;
  logic       valid;
  logic       ready;
  logic       func;
  logic [7:0] col;
  logic [7:0] row;
  logic [7:0] red_in;
  logic [7:0] green_in;
  logic [7:0] blue_in;
  logic [7:0] alpha_in;
  modport source(output valid, func, col, row, red_in, green_in, blue_in, alpha_in,
                 input ready);
  modport sink(input valid, func, col, row, red_in, green_in, blue_in, alpha_in,
               output ready);
endinterface

interface gbr_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] col_out;
  logic [7:0] row_out;
  logic [7:0] red_out;
  logic [7:0] green_out;
  logic [7:0] blue_out;
  logic [7:0] alpha_out;
  modport source(output valid, col_out, row_out, red_out, green_out, blue_out,
                 alpha_out, input ready);
  modport sink(input valid, col_out, row_out, red_out, green_out, blue_out,
               alpha_out, output ready);
endinterface

interface gbr_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [8:0]  data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface
`default_nettype wire

// ===== hdl/gbr_div.sv =====
// Restoring divider, one quotient bit per cycle.
// Depends on nothing.
`default_nettype none
module gbr_div #(
  parameter int NumW = 48,
  parameter int DenW = 48
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            start,
  input  wire logic [NumW-1:0] num,
  input  wire logic [DenW-1:0] den,
  output logic                 done,
  output logic [7:0]           quo
);
  localparam int CntW = $clog2(NumW + 1);
  logic [NumW-1:0] q;
  logic [DenW:0]   rem;
  logic [DenW-1:0] d;
  logic [CntW-1:0] cnt;
  logic            busy;
  logic [DenW:0]   trial;

  assign trial = {rem[DenW-1:0], q[NumW-1]};
  assign quo = q[7:0];

  // One shift/subtract step a cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt <= CntW'(NumW);
        q <= num;
        d <= den;
        rem <= '0;
      end else if (busy) begin
        if (trial >= {1'b0, d}) begin
          rem <= trial - {1'b0, d};
          q <= {q[NumW-2:0], 1'b1};
        end else begin
          rem <= trial;
          q <= {q[NumW-2:0], 1'b0};
        end
        cnt <= cnt - 1'b1;
        if (cnt == CntW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule
`default_nettype wire

// ===== hdl/gbr_datapath.sv =====
// Datapath: frame store, window address walk, weight products, sums, dividers.
// Depends on gbr_pkg and gbr_div.
`default_nettype none
module gbr_datapath #(
  parameter int MaxWidth = 256,
  parameter int MaxHeight = 256,
  parameter int MaxRadius = 4,
  // Coordinates are 8 bits, so the store never spans more than 256 by 256
  localparam int WCap = (MaxWidth > 256) ? 256 : MaxWidth,
  localparam int HCap = (MaxHeight > 256) ? 256 : MaxHeight,
  localparam int XW = (WCap > 1) ? $clog2(WCap) : 1,
  localparam int YW = (HCap > 1) ? $clog2(HCap) : 1
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire gbr_pkg::gbr_cmd_t cmd,
  output gbr_pkg::gbr_stat_t    stat,
  input  wire logic             wr_en,
  input  wire logic [7:0]       col,
  input  wire logic [7:0]       row,
  input  wire logic [31:0]      wr_pix,
  input  wire logic [2:0]       radius,
  input  wire logic [8:0]       img_w,
  input  wire logic [8:0]       img_h,
  output logic [7:0]            col_out,
  output logic [7:0]            row_out,
  output logic [31:0]           pix_out
);
  import gbr_pkg::*;
  localparam int AW = XW + YW;
  localparam int Depth = 1 << AW;
  localparam int RMax = (MaxRadius < TableRadii) ? MaxRadius : TableRadii;
  localparam int SumW = 48;
  localparam int AccW = 56;

  logic [31:0] mem [Depth];
  logic [31:0] rd_pix;

  // Request context
  logic [7:0] c_col, c_row;
  logic [SelW-1:0] sel;
  logic [8:0] x0, x1, y1, xc, yc;
  logic [15:0] wy, wx;
  logic [31:0] wt;
  logic [SumW-1:0] wsum;
  logic [AccW-1:0] acc [4];
  logic [7:0] quo [4];
  logic [3:0] dn;

  // Radius, size clamps
  logic [2:0] rcl;
  logic [8:0] wuse, huse;
  logic [TapW-1:0] reach;
  always_comb begin
    rcl = (radius == 3'd0) ? 3'd1 : radius;
    if (rcl > 3'(RMax)) rcl = 3'(RMax);
    wuse = (img_w == 9'd0) ? 9'd1 : img_w;
    if (wuse > 9'(WCap)) wuse = 9'(WCap);
    huse = (img_h == 9'd0) ? 9'd1 : img_h;
    if (huse > 9'(HCap)) huse = 9'(HCap);
  end
  assign reach = reach_of(SelW'(rcl - 3'd1));

  logic [8:0] dxw, dyw;
  assign dxw = (xc > {1'b0, c_col}) ? xc - {1'b0, c_col} : {1'b0, c_col} - xc;
  assign dyw = (yc > {1'b0, c_row}) ? yc - {1'b0, c_row} : {1'b0, c_row} - yc;
  assign stat.last = (xc == x1) && (yc == y1);
  assign stat.div_done = dn[0];

  logic [AW-1:0] wa, ra;
  assign wa = {row[YW-1:0], col[XW-1:0]};
  assign ra = {yc[YW-1:0], xc[XW-1:0]};
  logic wr_ok;
  assign wr_ok = ({1'b0, col} < 9'(WCap)) && ({1'b0, row} < 9'(HCap));

  // Frame store, one write or one read a cycle
  always_ff @(posedge clk) begin
    if (wr_en && wr_ok) mem[wa] <= wr_pix;
    if (cmd.step) rd_pix <= mem[ra];
  end

  // Window walk and weight product
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      c_col <= col;
      c_row <= row;
      sel <= SelW'(rcl - 3'd1);
      x0 <= ({1'b0, col} > {5'd0, reach}) ? {1'b0, col} - {5'd0, reach} : 9'd0;
      xc <= ({1'b0, col} > {5'd0, reach}) ? {1'b0, col} - {5'd0, reach} : 9'd0;
      yc <= ({1'b0, row} > {5'd0, reach}) ? {1'b0, row} - {5'd0, reach} : 9'd0;
      x1 <= ({1'b0, col} + {5'd0, reach} < wuse) ? {1'b0, col} + {5'd0, reach}
                                                  : wuse - 9'd1;
      y1 <= ({1'b0, row} + {5'd0, reach} < huse) ? {1'b0, row} + {5'd0, reach}
                                                  : huse - 9'd1;
    end else if (cmd.step) begin
      wx <= weight_of(sel, TapW'(dxw));
      wy <= weight_of(sel, TapW'(dyw));
      if (xc == x1) begin
        xc <= x0;
        yc <= yc + 9'd1;
      end else begin
        xc <= xc + 9'd1;
      end
    end
  end

  // Accumulate: product of the two weights, then four channel MACs next beat
  logic acc_d;
  always_ff @(posedge clk) begin
    if (rst) begin
      acc_d <= 1'b0;
    end else begin
      acc_d <= cmd.acc;
    end
  end
  logic [31:0] pix_d;
  always_ff @(posedge clk) begin
    if (cmd.acc) begin
      wt <= wx * wy;
      pix_d <= rd_pix;
    end
    if (cmd.load) begin
      wsum <= '0;
      for (int k = 0; k < 4; k++) acc[k] <= '0;
    end else if (acc_d) begin
      wsum <= wsum + SumW'(wt);
      for (int k = 0; k < 4; k++)
        acc[k] <= acc[k] + AccW'(wt) * AccW'(pix_d[8*k +: 8]);
    end
  end

  // Four dividers, rounded half up
  for (genvar k = 0; k < 4; k++) begin : g_div
    gbr_div #(.NumW(AccW), .DenW(SumW)) u_div (
      .clk, .rst, .start(cmd.div_go),
      .num(acc[k] + AccW'(wsum >> 1)), .den(wsum),
      .done(dn[k]), .quo(quo[k])
    );
  end

  // Output register
  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      col_out <= c_col;
      row_out <= c_row;
      pix_out <= {quo[3], quo[2], quo[1], quo[0]};
    end
  end
endmodule
`default_nettype wire

// ===== hdl/gbr_ctrl.sv =====
// Controller state machine for the blur block: handshakes and sequencing.
// Depends on gbr_pkg.
`default_nettype none
module gbr_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic              in_func,
  input  wire logic              in_range,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output gbr_pkg::gbr_cmd_t      cmd,
  input  wire gbr_pkg::gbr_stat_t stat
);
  import gbr_pkg::*;
  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_WALK = 6'b000010,
    S_TAIL = 6'b000100,
    S_DIV  = 6'b001000,
    S_WAIT = 6'b010000,
    S_EMIT = 6'b100000
  } state_t;
  state_t state, state_next;
  logic [1:0] tail;
  logic start_rd;
  // Accumulate follows the read, delayed through step_d
  logic step_d;

  assign in_ready = (state == S_IDLE);
  assign start_rd = in_valid && in_ready && (in_func == FUNC_READ) && in_range;

  always_comb begin
    state_next = state;
    cmd = '0;
    cmd.acc = step_d;
    unique case (state)
      S_IDLE: if (start_rd) begin
        cmd.load = 1'b1;
        state_next = S_WALK;
      end
      S_WALK: begin
        cmd.step = 1'b1;
        if (stat.last) state_next = S_TAIL;
      end
      S_TAIL: if (tail == 2'd3) state_next = S_DIV;
      S_DIV: begin
        cmd.div_go = 1'b1;
        state_next = S_WAIT;
      end
      S_WAIT: if (stat.div_done) begin
        state_next = S_EMIT;
        cmd.emit = !out_valid || out_ready;
        if (out_valid && !out_ready) state_next = S_EMIT;
        else state_next = S_IDLE;
      end
      S_EMIT: if (!out_valid || out_ready) begin
        cmd.emit = 1'b1;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
      step_d <= 1'b0;
      tail <= '0;
    end else begin
      state <= state_next;
      step_d <= cmd.step;
      tail <= (state == S_TAIL) ? tail + 2'd1 : 2'd0;
      if (cmd.emit) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end
endmodule
`default_nettype wire

// ===== hdl/gaussian_blur_rgba.sv =====
// Top level of the RGBA Gaussian blur block.
// Depends on gbr_pkg, gbr_if, gbr_ctrl, gbr_datapath, gbr_div.
//
// A write beat stores one pixel. A read beat walks the clipped window, one
// frame-store read per cycle (up to 23 x 23 = 529 reads at radius 4), drains
// the accumulate tail, starts four bit-serial dividers that run side by side
// for 56 steps and loads the output register, after any wait while the
// previous result still sits unaccepted in the output register. The
// single-port frame store read and the bit-serial dividers set the pace of
// a read; a new beat is taken only with the block idle. The frame store is
// not cleared; reading a never-written pixel returns unknown data.
`default_nettype none
module gaussian_blur_rgba #(
  parameter int MaxWidth = gbr_pkg::DefMaxWidth,
  parameter int MaxHeight = gbr_pkg::DefMaxHeight,
  parameter int MaxRadius = gbr_pkg::DefMaxRadius
) (
  input wire logic clk,
  input wire logic rst,
  gbr_in_if.sink   in_ch,
  gbr_out_if.source out_ch,
  gbr_cfg_if.sink  cfg
);
  import gbr_pkg::*;
  // Coordinates are 8 bits, so the image never spans more than 256 by 256
  localparam int WCap = (MaxWidth > 256) ? 256 : MaxWidth;
  localparam int HCap = (MaxHeight > 256) ? 256 : MaxHeight;
  logic [2:0] blur_radius;
  logic [8:0] image_width, image_height;
  gbr_cmd_t cmd;
  gbr_stat_t stat;
  logic [31:0] pix;
  logic in_range;

  // Configuration registers
  assign cfg.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      blur_radius <= 3'd1;
      image_width <= 9'd256;
      image_height <= 9'd256;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_RADIUS: blur_radius <= cfg.data[2:0];
        REG_WIDTH:  image_width <= cfg.data;
        REG_HEIGHT: image_height <= cfg.data;
        default: ;
      endcase
    end
  end

  // Request must lie inside the image in use
  logic [8:0] wuse, huse;
  always_comb begin
    wuse = (image_width == 9'd0) ? 9'd1 : image_width;
    if (wuse > 9'(WCap)) wuse = 9'(WCap);
    huse = (image_height == 9'd0) ? 9'd1 : image_height;
    if (huse > 9'(HCap)) huse = 9'(HCap);
  end
  assign in_range = ({1'b0, in_ch.col} < wuse) && ({1'b0, in_ch.row} < huse);

  gbr_ctrl u_ctrl (
    .clk, .rst,
    .in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_func(in_ch.func),
    .in_range, .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .cmd, .stat
  );

  gbr_datapath #(.MaxWidth(MaxWidth), .MaxHeight(MaxHeight), .MaxRadius(MaxRadius))
  u_dp (
    .clk, .rst, .cmd, .stat,
    .wr_en(in_ch.valid && in_ch.ready && (in_ch.func == FUNC_WRITE)),
    .col(in_ch.col), .row(in_ch.row),
    .wr_pix({in_ch.alpha_in, in_ch.blue_in, in_ch.green_in, in_ch.red_in}),
    .radius(blur_radius), .img_w(image_width), .img_h(image_height),
    .col_out(out_ch.col_out), .row_out(out_ch.row_out), .pix_out(pix)
  );

  assign out_ch.red_out = pix[7:0];
  assign out_ch.green_out = pix[15:8];
  assign out_ch.blue_out = pix[23:16];
  assign out_ch.alpha_out = pix[31:24];
endmodule
`default_nettype wire

// ===== dv/gaussian_blur_rgba_check.sv =====
// Checker for the RGBA Gaussian blur: watches the pixel, result and register
// channels, predicts each blurred pixel and compares. Depends on gbr_pkg, gbr_if.
`timescale 1ns / 100ps
module gaussian_blur_rgba_check (
  input  wire logic clk,
  input  wire logic rst,
  gbr_in_if         in_ch,
  gbr_out_if        out_ch,
  gbr_cfg_if        cfg,
  output int        errors,
  output int        pending
);
  import gbr_pkg::*;

  typedef struct packed {
    logic [7:0] col;
    logic [7:0] row;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
  } blur_pix_t;

  // Q0.16 Gaussian taps per radius, and window reach per radius
  localparam logic [15:0] Taps [4][12] = '{
    '{16'd65535, 16'd39750, 16'd8869, 16'd728, 16'd0, 16'd0, 16'd0, 16'd0,
      16'd0, 16'd0, 16'd0, 16'd0},
    '{16'd65535, 16'd57835, 16'd39750, 16'd21276, 16'd8869, 16'd2879, 16'd728,
      16'd0, 16'd0, 16'd0, 16'd0, 16'd0},
    '{16'd65535, 16'd61994, 16'd52477, 16'd39750, 16'd26943, 16'd16342,
      16'd8869, 16'd4308, 16'd1872, 16'd0, 16'd0, 16'd0},
    '{16'd65535, 16'd63520, 16'd57835, 16'd49469, 16'd39750, 16'd30005,
      16'd21276, 16'd14173, 16'd8869, 16'd5214, 16'd2879, 16'd1494}
  };
  localparam int Reach [4] = '{3, 6, 8, 11};

  logic [31:0] pixels [65536];
  logic [2:0]  radius;
  logic [8:0]  width;
  logic [8:0]  height;
  blur_pix_t   blurred_q [$];

  assign pending = blurred_q.size();

  // Weighted window mean, rounded half up per channel
  function automatic blur_pix_t blur_at(input logic [7:0] c, input logic [7:0] r);
    int w_use, h_use, sel, rch, x0, x1, y0, y1, dx, dy;
    logic [63:0] wsum, wt;
    logic [63:0] acc [4];
    logic [31:0] p;
    blur_pix_t res;
    w_use = (width == 0) ? 1 : (width > 256) ? 256 : width;
    h_use = (height == 0) ? 1 : (height > 256) ? 256 : height;
    sel = (radius == 0) ? 0 : (radius > 4) ? 3 : radius - 1;
    rch = Reach[sel];
    x0 = (c > rch) ? c - rch : 0;
    y0 = (r > rch) ? r - rch : 0;
    x1 = (c + rch < w_use) ? c + rch : w_use - 1;
    y1 = (r + rch < h_use) ? r + rch : h_use - 1;
    wsum = 0;
    for (int k = 0; k < 4; k++) acc[k] = 0;
    for (int y = y0; y <= y1; y++) begin
      dy = (y > r) ? y - r : r - y;
      for (int x = x0; x <= x1; x++) begin
        dx = (x > c) ? x - c : c - x;
        wt = 64'(Taps[sel][dy]) * 64'(Taps[sel][dx]);
        p = pixels[y * 256 + x];
        wsum += wt;
        for (int k = 0; k < 4; k++) acc[k] += wt * 64'(p[8*k +: 8]);
      end
    end
    res.col = c;
    res.row = r;
    res.red = 8'((acc[0] + wsum / 2) / wsum);
    res.green = 8'((acc[1] + wsum / 2) / wsum);
    res.blue = 8'((acc[2] + wsum / 2) / wsum);
    res.alpha = 8'((acc[3] + wsum / 2) / wsum);
    return res;
  endfunction

  // Register writes
  always @(posedge clk) begin
    if (rst) begin
      radius <= 3'd1;
      width <= 9'd256;
      height <= 9'd256;
    end else if (cfg.valid && cfg.ready) begin
      case (cfg.index)
        REG_RADIUS: radius <= cfg.data[2:0];
        REG_WIDTH: width <= cfg.data;
        REG_HEIGHT: height <= cfg.data;
        default: ;
      endcase
    end
  end

  // Pixel beats: store writes, predict reads inside the image
  always @(posedge clk) begin
    int w_use, h_use;
    w_use = (width == 0) ? 1 : (width > 256) ? 256 : width;
    h_use = (height == 0) ? 1 : (height > 256) ? 256 : height;
    if (!rst && in_ch.valid && in_ch.ready) begin
      if (in_ch.func == FUNC_WRITE)
        pixels[{in_ch.row, in_ch.col}] = {in_ch.alpha_in, in_ch.blue_in,
                                         in_ch.green_in, in_ch.red_in};
      else if (in_ch.col < w_use && in_ch.row < h_use)
        blurred_q.push_back(blur_at(in_ch.col, in_ch.row));
    end
  end

  // Result beats
  always @(posedge clk) begin
    blur_pix_t got, want;
    if (rst) begin
      errors <= 0;
    end else if (out_ch.valid && out_ch.ready) begin
      got = {out_ch.col_out, out_ch.row_out, out_ch.red_out, out_ch.green_out,
             out_ch.blue_out, out_ch.alpha_out};
      if (blurred_q.size() == 0) begin
        $display("%0t: unexpected result beat %h", $time, got);
        errors <= errors + 1;
      end else begin
        want = blurred_q.pop_front();
        if (got.col != want.col || got.row != want.row || got.red != want.red ||
            got.green != want.green || got.blue != want.blue ||
            got.alpha != want.alpha) begin
          $display("%0t: mismatch at (%0d,%0d): expected rgba %0d %0d %0d %0d, got (%0d,%0d) %0d %0d %0d %0d",
                   $time, want.col, want.row, want.red, want.green, want.blue,
                   want.alpha, got.col, got.row, got.red, got.green, got.blue,
                   got.alpha);
          errors <= errors + 1;
        end
      end
    end
  end
endmodule

// ===== dv/gaussian_blur_rgba_test.sv =====
// Top of the blur testbench: clock, reset, pixel and register stimulus, verdict.
// Depends on gbr_pkg, gbr_if, gaussian_blur_rgba and gaussian_blur_rgba_check.
`timescale 1ns / 100ps
module gaussian_blur_rgba_test;
  import gbr_pkg::*;

  localparam int CycleLimit = 4000000;

  logic clk;
  logic rst;
  int   errors;
  int   pending;
  int   send_idle;
  int   recv_idle;
  bit   hold_req;
  int   cycles;
  int   cur_w;
  int   cur_h;

  gbr_in_if  in_ch ();
  gbr_out_if out_ch ();
  gbr_cfg_if cfg ();

  gaussian_blur_rgba dut (.clk(clk), .rst(rst), .in_ch(in_ch), .out_ch(out_ch),
                          .cfg(cfg));

  gaussian_blur_rgba_check checker_i (.clk(clk), .rst(rst), .in_ch(in_ch),
                                      .out_ch(out_ch), .cfg(cfg), .errors(errors),
                                      .pending(pending));

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Timeout
  initial cycles = 0;
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Result side: random stalls, plus one long hold-off on request
  initial hold_req = 1'b0;
  always @(negedge clk) begin
    int held;
    if (hold_req) begin
      held = 0;
      while (held < 4000) begin
        out_ch.ready <= 1'b0;
        @(negedge clk);
        held++;
      end
      hold_req = 1'b0;
    end
    out_ch.ready <= ($urandom_range(99) >= recv_idle);
  end

  // One pixel beat; entered and left at a falling edge
  task automatic send_pix(input logic f, input logic [7:0] c, input logic [7:0] r,
                          input logic [31:0] px);
    while ($urandom_range(99) < send_idle) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.func <= f;
    in_ch.col <= c;
    in_ch.row <= r;
    {in_ch.alpha_in, in_ch.blue_in, in_ch.green_in, in_ch.red_in} <= px;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
  endtask

  // Register write, only with the block drained
  task automatic set_reg(input logic [1:0] idx, input logic [8:0] val);
    in_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (50) @(negedge clk);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data <= val;
    do @(posedge clk); while (!cfg.ready);
    @(negedge clk);
    cfg.valid <= 1'b0;
    if (idx == REG_WIDTH) cur_w = (val == 0) ? 1 : (val > 256) ? 256 : val;
    if (idx == REG_HEIGHT) cur_h = (val == 0) ? 1 : (val > 256) ? 256 : val;
  endtask

  task automatic set_shape(input logic [8:0] rad, input logic [8:0] w,
                           input logic [8:0] h);
    set_reg(REG_RADIUS, rad);
    set_reg(REG_WIDTH, w);
    set_reg(REG_HEIGHT, h);
  endtask

  // Random beats under one random setting; the image stays inside the
  // filled 16 x 16 corner, reads mostly inside the image
  task automatic random_phase(input int n);
    int kind;
    logic [7:0] c, r;
    set_shape(9'($urandom_range(1, 4)),
              ($urandom_range(1) == 1) ? 9'($urandom_range(1, 4)) : 9'($urandom_range(1, 16)),
              ($urandom_range(1) == 1) ? 9'($urandom_range(1, 4)) : 9'($urandom_range(1, 16)));
    for (int i = 0; i < n; i++) begin
      kind = $urandom_range(99);
      if (kind < 30) begin
        send_pix(FUNC_WRITE, 8'($urandom_range(255)), 8'($urandom_range(255)), $urandom);
      end else begin
        c = (kind < 92) ? 8'($urandom_range(cur_w - 1)) : 8'($urandom_range(255));
        r = (kind < 92) ? 8'($urandom_range(cur_h - 1)) : 8'($urandom_range(255));
        send_pix(FUNC_READ, c, r, $urandom);
      end
    end
  endtask

  initial begin
    rst = 1'b1;
    in_ch.valid = 1'b0;
    in_ch.func = FUNC_WRITE;
    in_ch.col = 8'd0;
    in_ch.row = 8'd0;
    in_ch.red_in = 8'd0;
    in_ch.green_in = 8'd0;
    in_ch.blue_in = 8'd0;
    in_ch.alpha_in = 8'd0;
    out_ch.ready = 1'b0;
    cfg.valid = 1'b0;
    cfg.index = REG_RADIUS;
    cfg.data = 9'd0;
    send_idle = 0;
    recv_idle = 0;
    cur_w = 256;
    cur_h = 256;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Fill the 16 x 16 corner; every read window but the one at (255, 255) stays inside it
    for (int i = 0; i < 256; i++)
      send_pix(FUNC_WRITE, {4'd0, i[3:0]}, {4'd0, i[7:4]}, $urandom);

    // Directed: extreme pixels, corners, reset setting
    send_pix(FUNC_WRITE, 8'd0, 8'd0, 32'hFFFF_FFFF);
    send_pix(FUNC_WRITE, 8'd15, 8'd15, 32'h0000_0000);
    send_pix(FUNC_READ, 8'd0, 8'd0, 32'h0);
    send_pix(FUNC_READ, 8'd12, 8'd12, 32'h0);
    send_pix(FUNC_READ, 8'd7, 8'd4, 32'h0);
    // largest radius, full image
    set_shape(9'd4, 9'd256, 9'd256);
    send_pix(FUNC_READ, 8'd0, 8'd0, 32'h0);
    send_pix(FUNC_READ, 8'd4, 8'd4, 32'h0);
    // radius above range saturates, size above range saturates
    set_shape(9'd7, 9'd511, 9'd300);
    send_pix(FUNC_READ, 8'd3, 8'd2, 32'h0);
    // radius zero acts as one, size zero acts as one: single pixel image
    set_shape(9'd0, 9'd0, 9'd0);
    send_pix(FUNC_READ, 8'd0, 8'd0, 32'h0);
    send_pix(FUNC_READ, 8'd1, 8'd0, 32'h0);
    send_pix(FUNC_READ, 8'd0, 8'd1, 32'h0);
    // write outside the image in use is still stored, read back later
    send_pix(FUNC_WRITE, 8'd3, 8'd3, 32'h1234_5678);
    // unknown register index is ignored
    set_reg(2'd3, 9'h1FF);
    // narrow image, reads just outside are dropped
    set_shape(9'd2, 9'd5, 9'd3);
    send_pix(FUNC_READ, 8'd4, 8'd2, 32'h0);
    send_pix(FUNC_READ, 8'd5, 8'd2, 32'h0);
    send_pix(FUNC_READ, 8'd4, 8'd3, 32'h0);
    set_shape(9'd3, 9'd256, 9'd256);
    send_pix(FUNC_READ, 8'd4, 8'd7, 32'h0);
    send_pix(FUNC_READ, 8'd255, 8'd255, 32'h0);

    // Random part: receiver idles more, then sender, then neither
    send_idle = 36;
    recv_idle = 58;
    repeat (6) random_phase(45);
    send_idle = 58;
    recv_idle = 36;
    repeat (6) random_phase(45);
    send_idle = 0;
    recv_idle = 0;
    // result side held off while reads keep coming
    set_shape(9'd1, 9'd16, 9'd16);
    hold_req = 1'b1;
    for (int i = 0; i < 40; i++)
      send_pix(FUNC_READ, 8'($urandom_range(15)), 8'($urandom_range(15)), $urandom);
    repeat (6) random_phase(45);
    in_ch.valid <= 1'b0;

    while (pending != 0) @(negedge clk);
    repeat (700) @(negedge clk);
    if (errors == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end
endmodule
